// ===== rtl/gpfp_pkg.sv =====
// Shared constants and types of the gamepad frame parser.
package gpfp_pkg;

   localparam logic [7:0] SYNC_BYTE  = 8'h67;
   localparam logic [7:0] CHECK_MARK = 8'h80;

   localparam int unsigned BUTTON_W = 7;
   localparam int unsigned STICK_W  = 8;
   localparam int unsigned NIBBLE_W = 4;

   // Payload positions that feed the result.
   localparam int unsigned SLOT_TRIANGLE = 0;
   localparam int unsigned SLOT_CIRCLE   = 1;
   localparam int unsigned SLOT_CROSS    = 2;
   localparam int unsigned SLOT_SQUARE   = 3;
   localparam int unsigned SLOT_LSX_HI   = 4;
   localparam int unsigned SLOT_LSX_LO   = 5;
   localparam int unsigned SLOT_LSY_HI   = 6;
   localparam int unsigned SLOT_LSY_LO   = 7;
   localparam int unsigned SLOT_RSY_HI   = 10;
   localparam int unsigned SLOT_RSY_LO   = 11;

   localparam logic FRAME_GOOD = 1'b0;
   localparam logic FRAME_BAD  = 1'b1;

   typedef struct packed {
      logic                  frame_status;
      logic [BUTTON_W-1:0]   button_triangle;
      logic [BUTTON_W-1:0]   button_circle;
      logic [BUTTON_W-1:0]   button_cross;
      logic [BUTTON_W-1:0]   button_square;
      logic [STICK_W-1:0]    left_stick_x;
      logic [STICK_W-1:0]    left_stick_y;
      logic [STICK_W-1:0]    right_stick_y;
   } gpfp_result_type;

   // What the frame tracker reports to the output stage.
   typedef struct packed {
      logic            at_final;   // next accepted byte closes the frame
      logic            emit;       // this accepted byte closes the frame
      gpfp_result_type result;
   } gpfp_track_type;

endpackage

// ===== rtl/gpfp_frame_tracker.sv =====
// Frame phase, running checks and capture of the payload bytes used in the result.
module gpfp_frame_tracker
   import gpfp_pkg::*;
#(
   parameter int unsigned PAYLOAD_LEN = 15
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_valid,
   input  logic [7:0]     byte_data,
   output gpfp_track_type track
);

   localparam int unsigned PHASE_W   = $clog2(PAYLOAD_LEN + 3);
   localparam logic [PHASE_W-1:0] PH_HUNT  = '0;
   localparam logic [PHASE_W-1:0] PH_XOR   = PHASE_W'(PAYLOAD_LEN + 1);
   localparam logic [PHASE_W-1:0] PH_SUM   = PHASE_W'(PAYLOAD_LEN + 2);

   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [7:0]          xor_ff, xor_in;
   logic [7:0]          sum_ff, sum_in;
   logic [7:0]          rx_xor_ff, rx_xor_in;

   // Only the payload bits that reach the result are kept.
   logic [BUTTON_W-1:0] button_ff [4];
   logic [NIBBLE_W-1:0] nibble_ff [6];

   logic in_payload;
   logic frame_ok;

   assign in_payload = (phase_ff != PH_HUNT) && (phase_ff < PH_XOR);

   always_comb begin
      phase_in  = phase_ff;
      xor_in    = xor_ff;
      sum_in    = sum_ff;
      rx_xor_in = rx_xor_ff;
      if (byte_valid) begin
         priority if (phase_ff == PH_HUNT) begin
            if (byte_data == SYNC_BYTE) begin
               xor_in   = '0;
               sum_in   = '0;
               phase_in = PHASE_W'(1);
            end
         end else if (in_payload) begin
            xor_in   = xor_ff ^ byte_data;
            sum_in   = sum_ff + byte_data;
            phase_in = phase_ff + PHASE_W'(1);
         end else if (phase_ff == PH_XOR) begin
            rx_xor_in = byte_data;
            phase_in  = PH_SUM;
         end else begin
            phase_in = PH_HUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         xor_ff    <= '0;
         sum_ff    <= '0;
         rx_xor_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         xor_ff    <= xor_in;
         sum_ff    <= sum_in;
         rx_xor_ff <= rx_xor_in;
      end
   end

   // Payload slot k arrives while the phase equals k + 1.
   always_ff @(posedge clock) begin
      if (byte_valid) begin
         if (phase_ff == PHASE_W'(SLOT_TRIANGLE + 1)) button_ff[0] <= byte_data[BUTTON_W-1:0];
         if (phase_ff == PHASE_W'(SLOT_CIRCLE + 1))   button_ff[1] <= byte_data[BUTTON_W-1:0];
         if (phase_ff == PHASE_W'(SLOT_CROSS + 1))    button_ff[2] <= byte_data[BUTTON_W-1:0];
         if (phase_ff == PHASE_W'(SLOT_SQUARE + 1))   button_ff[3] <= byte_data[BUTTON_W-1:0];
         if (phase_ff == PHASE_W'(SLOT_LSX_HI + 1))   nibble_ff[0] <= byte_data[NIBBLE_W-1:0];
         if (phase_ff == PHASE_W'(SLOT_LSX_LO + 1))   nibble_ff[1] <= byte_data[NIBBLE_W-1:0];
         if (phase_ff == PHASE_W'(SLOT_LSY_HI + 1))   nibble_ff[2] <= byte_data[NIBBLE_W-1:0];
         if (phase_ff == PHASE_W'(SLOT_LSY_LO + 1))   nibble_ff[3] <= byte_data[NIBBLE_W-1:0];
         if (phase_ff == PHASE_W'(SLOT_RSY_HI + 1))   nibble_ff[4] <= byte_data[NIBBLE_W-1:0];
         if (phase_ff == PHASE_W'(SLOT_RSY_LO + 1))   nibble_ff[5] <= byte_data[NIBBLE_W-1:0];
      end
   end

   assign frame_ok = ((xor_ff | CHECK_MARK) == rx_xor_ff) &&
                     ((sum_ff | CHECK_MARK) == byte_data);

   always_comb begin
      track.at_final = (phase_ff == PH_SUM);
      track.emit     = byte_valid && (phase_ff == PH_SUM);
      track.result   = '0;
      if (frame_ok) begin
         track.result.frame_status    = FRAME_GOOD;
         track.result.button_triangle = button_ff[0];
         track.result.button_circle   = button_ff[1];
         track.result.button_cross    = button_ff[2];
         track.result.button_square   = button_ff[3];
         track.result.left_stick_x    = {nibble_ff[0], nibble_ff[1]};
         track.result.left_stick_y    = {nibble_ff[2], nibble_ff[3]};
         track.result.right_stick_y   = {nibble_ff[4], nibble_ff[5]};
      end else begin
         track.result.frame_status = FRAME_BAD;
      end
   end

endmodule

// ===== rtl/gamepad_frame_parser.sv =====
// Top level of the gamepad frame parser: request channel, frame tracker, result register.
//
// The request channel carries one received link byte per request in req_tdata.
// The block hunts for the sync byte 'g', then takes PAYLOAD_LEN payload bytes,
// an XOR check byte and a sum check byte. The request that carries the sum
// check byte produces one response; all other requests produce none.
// The response carries the frame status in rsp_tuser (0 good, 1 checksum
// mismatch) and the decoded buttons and sticks in rsp_tdata; on a mismatch
// all data fields are zero.
// Throughput is one request per cycle, except while a closing request waits. The response
// appears in rsp_tdata in the cycle after the closing request is accepted, held in a
// single result register. A frame spans PAYLOAD_LEN + 3 requests, so the result
// register is normally empty again long before the next frame closes.
// When the receiver stalls, requests keep flowing; only the request that would
// close a frame waits (req_tready low) while an untaken response still sits in
// the result register.
// Reset returns the tracker to sync hunting, clears the running checks and
// empties the result register.
module gamepad_frame_parser
   import gpfp_pkg::*;
#(
   parameter int unsigned PAYLOAD_LEN = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [6:0] button_triangle, [13:7] button_circle,
                                    // [20:14] button_cross, [27:21] button_square,
                                    // [35:28] left_stick_x, [43:36] left_stick_y,
                                    // [51:44] right_stick_y, [55:52] zero
   output logic        rsp_tuser    // [0] frame_status
);

   gpfp_track_type  track;
   logic            req_fire;
   logic            rsp_valid_ff, rsp_valid_in;
   gpfp_result_type rsp_data_ff;

   // Only the closing byte needs room in the result register.
   assign req_tready = !(track.at_final && rsp_valid_ff && !rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   gpfp_frame_tracker #(
      .PAYLOAD_LEN(PAYLOAD_LEN)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(req_fire),
      .byte_data (req_tdata),
      .track     (track)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (track.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (track.emit) begin
         rsp_data_ff <= track.result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.frame_status;
   assign rsp_tdata  = {4'b0000,
                        rsp_data_ff.right_stick_y,
                        rsp_data_ff.left_stick_y,
                        rsp_data_ff.left_stick_x,
                        rsp_data_ff.button_square,
                        rsp_data_ff.button_cross,
                        rsp_data_ff.button_circle,
                        rsp_data_ff.button_triangle};

endmodule
